// File: design/lift_motor_limit_controller_assert.svh
// Assertion macros shared by the lift motor limit controller modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef LIFT_MOTOR_LIMIT_CONTROLLER_ASSERT_SVH
`define LIFT_MOTOR_LIMIT_CONTROLLER_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define LMLC_ASSERT(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define LMLC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lmlc_pkg.sv
// Shared types and constants of the lift motor limit controller.
// Depends on nothing; used by every module of the block.
package lmlc_pkg;

  localparam int COUNT_WIDTH_DEFAULT = 16;
  localparam int CFG_WIDTH           = 16;
  localparam int CFG_INDEX_WIDTH     = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RUN_TIMEOUT    = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOCKOUT_START  = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LOCKOUT_STOP   = 2'd2;

  localparam logic [CFG_WIDTH-1:0] RUN_TIMEOUT_RESET   = 16'd4000;
  localparam logic [CFG_WIDTH-1:0] LOCKOUT_START_RESET = 16'd400;
  localparam logic [CFG_WIDTH-1:0] LOCKOUT_STOP_RESET  = 16'd1000;

  typedef enum logic [2:0] {
    MODE_OFF  = 3'b001,
    MODE_UP   = 3'b010,
    MODE_DOWN = 3'b100
  } mode_t;

  typedef struct packed {
    logic top_first;
    logic bottom_first;
    logic button_first;
    logic top_second;
    logic bottom_second;
    logic button_second;
    logic bottom_now;
  } in_item_t;

  typedef struct packed {
    logic up_drive_n;
    logic down_drive_n;
    logic led_level;
  } out_item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] run_timeout_ticks;
    logic [CFG_WIDTH-1:0] lockout_after_start;
    logic [CFG_WIDTH-1:0] lockout_after_stop;
  } cfg_t;

endpackage

// File: design/lmlc_cfg_regs.sv
// Configuration register file of the lift motor limit controller.
// Depends on lmlc_pkg.
module lmlc_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [lmlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lmlc_pkg::CFG_WIDTH-1:0]       cfg_data,
  output lmlc_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_timeout_ticks   <= lmlc_pkg::RUN_TIMEOUT_RESET;
      cfg.lockout_after_start <= lmlc_pkg::LOCKOUT_START_RESET;
      cfg.lockout_after_stop  <= lmlc_pkg::LOCKOUT_STOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        lmlc_pkg::REG_RUN_TIMEOUT:   cfg.run_timeout_ticks   <= cfg_data;
        lmlc_pkg::REG_LOCKOUT_START: cfg.lockout_after_start <= cfg_data;
        lmlc_pkg::REG_LOCKOUT_STOP:  cfg.lockout_after_stop  <= cfg_data;
        default: ;  // unmapped index: write dropped
      endcase
    end
  end

endmodule

// File: design/lmlc_core.sv
// Motor state registers and the per-tick update of the lift controller.
// Depends on lmlc_pkg and the assertion macro header.
`include "lift_motor_limit_controller_assert.svh"

module lmlc_core #(
  parameter int COUNT_WIDTH = lmlc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step_en,
  input  lmlc_pkg::in_item_t item,
  input  lmlc_pkg::cfg_t     cfg,
  output lmlc_pkg::out_item_t result
);

  localparam int CMP_W = (COUNT_WIDTH > lmlc_pkg::CFG_WIDTH) ? COUNT_WIDTH
                                                             : lmlc_pkg::CFG_WIDTH;

  lmlc_pkg::mode_t        mode, mode_next;
  logic [COUNT_WIDTH-1:0] run_ticks, run_ticks_next;
  logic [COUNT_WIDTH-1:0] lockout, lockout_next;
  logic                   led_on, led_on_next;

  logic top_hit, bottom_hit, button_hit;
  logic start_fire;
  logic [COUNT_WIDTH-1:0] stop_load, start_load;

  assign top_hit    = !item.top_first    && !item.top_second;
  assign bottom_hit = !item.bottom_first && !item.bottom_second;
  assign button_hit = !item.button_first && !item.button_second;
  assign stop_load  = COUNT_WIDTH'(cfg.lockout_after_stop);
  assign start_load = COUNT_WIDTH'(cfg.lockout_after_start);

  always_comb begin
    mode_next      = mode;
    run_ticks_next = run_ticks;
    lockout_next   = lockout;
    led_on_next    = led_on;
    start_fire     = 1'b0;

    // limit in direction of travel
    if ((mode_next == lmlc_pkg::MODE_UP && top_hit) ||
        (mode_next == lmlc_pkg::MODE_DOWN && bottom_hit)) begin
      mode_next    = lmlc_pkg::MODE_OFF;
      lockout_next = stop_load;
      led_on_next  = 1'b1;
    end

    // run timeout, compared before increment
    if (mode_next == lmlc_pkg::MODE_UP || mode_next == lmlc_pkg::MODE_DOWN) begin
      run_ticks_next = run_ticks + 1'b1;
      if (CMP_W'(run_ticks) > CMP_W'(cfg.run_timeout_ticks)) begin
        mode_next    = lmlc_pkg::MODE_OFF;
        lockout_next = stop_load;
        led_on_next  = 1'b1;
      end
    end

    if (lockout_next != '0) begin
      lockout_next = lockout_next - 1'b1;
    end

    // button toggles once lockout expired
    if (lockout_next == '0 && button_hit) begin
      led_on_next = 1'b1;
      if (mode_next == lmlc_pkg::MODE_UP || mode_next == lmlc_pkg::MODE_DOWN) begin
        mode_next    = lmlc_pkg::MODE_OFF;
        lockout_next = stop_load;
      end else begin
        start_fire     = 1'b1;
        mode_next      = item.bottom_now ? lmlc_pkg::MODE_DOWN : lmlc_pkg::MODE_UP;
        run_ticks_next = '0;
        lockout_next   = start_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= lmlc_pkg::MODE_OFF;
      run_ticks <= '0;
      lockout   <= '0;
      led_on    <= 1'b0;
    end else if (step_en) begin
      mode      <= mode_next;
      run_ticks <= run_ticks_next;
      lockout   <= lockout_next;
      led_on    <= led_on_next;
    end
  end

  always_comb begin
    result.up_drive_n   = 1'b1;
    result.down_drive_n = 1'b1;
    case (mode_next)
      lmlc_pkg::MODE_UP:   result.up_drive_n   = 1'b0;
      lmlc_pkg::MODE_DOWN: result.down_drive_n = 1'b0;
      default: ;
    endcase
    result.led_level = led_on_next;
  end

  `LMLC_ASSERT_NEXT(a_led_sticky, clk, rst, led_on, led_on, "LED cleared after being set")
  `LMLC_ASSERT_NEXT(a_hold_when_idle, clk, rst, !step_en,
                    $stable(mode) && $stable(run_ticks) && $stable(lockout),
                    "state changed without a tick")
  `LMLC_ASSERT_NEXT(a_start_clears_run, clk, rst, step_en && start_fire,
                    run_ticks == '0 && lockout == start_load,
                    "start did not clear run count or load lockout")

endmodule

// File: design/lift_motor_limit_controller.sv
// Top level of the lift motor limit controller: input and result registers
// around the per-tick update. Depends on lmlc_pkg, lmlc_cfg_regs, lmlc_core.
//
// Use:
// - Input channel (in_valid/in_stall/in_data) carries one tick: two samples
//   of the top, bottom and start switches plus the bottom level read at the
//   start decision. All switches are active low.
// - Output channel (out_valid/out_stall/out_data) returns one transaction per
//   tick: up and down motor pin levels (active low) and the LED level.
// - An accepted tick waits in the input register, then the state update lands
//   in the result register.
// - Throughput is one tick per clock while out_stall is low; the state update
//   is a single pass of short logic between the input and result registers.
// - When the receiver stalls, the result register holds; the input register
//   still takes one more transaction if empty, then in_stall rises until the
//   result is taken.
// - Configuration writes (cfg_write/cfg_index/cfg_data) land in the next cycle;
//   write only while no transaction is in flight. Unmapped indexes drop.
// - Synchronous reset clears the motor to off, the counters and the LED,
//   restores register defaults and empties both pipeline registers.
`include "lift_motor_limit_controller_assert.svh"

module lift_motor_limit_controller #(
  parameter int COUNT_WIDTH = lmlc_pkg::COUNT_WIDTH_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  lmlc_pkg::in_item_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output lmlc_pkg::out_item_t                  out_data,
  input  logic                                 cfg_write,
  input  logic [lmlc_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [lmlc_pkg::CFG_WIDTH-1:0]       cfg_data
);

  lmlc_pkg::cfg_t      cfg;
  lmlc_pkg::in_item_t  item;
  logic                item_valid;
  lmlc_pkg::out_item_t result;
  logic                advance;
  logic                step_en;

  // result register frees up when empty or being taken this cycle
  assign advance  = !out_valid || !out_stall;
  assign step_en  = item_valid && advance;
  assign in_stall = item_valid && !advance;

  lmlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_data;
    end
  end

  lmlc_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .item    (item),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      out_data <= result;
    end
  end

  // backpressure only ever comes from a held result
  `LMLC_ASSERT(a_stall_source, clk, rst, !in_stall || (out_valid && out_stall),
               "input stalled without a held result")

endmodule
